### design/cstc_pkg.sv
package cstc_pkg;

  // command bytes
  localparam logic [7:0] CMD_TICK = 8'hff;
  localparam logic [7:0] CMD_WAIT = 8'hfe;
  localparam logic [7:0] CMD_END  = 8'hfd;

  // varint byte layout
  localparam logic [7:0] VARINT_MORE     = 8'h80;
  localparam int         VARINT_BITS     = 7;
  localparam int         VARINT_WIDTH    = 32;
  localparam int         SHIFT_WIDTH     = 6;
  localparam logic [63:0] WAIT_BASE_TICKS = 64'd2;

  // configuration register indexes
  localparam logic CFG_DATA_START  = 1'b0;
  localparam logic CFG_LOOP_OFFSET = 1'b1;

  typedef enum logic [2:0] {
    PH_CMD    = 3'd0,
    PH_SKIP1  = 3'd1,
    PH_SKIP2  = 3'd2,
    PH_VARINT = 3'd3,
    PH_DONE   = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NO_TICKS  = 2'd1,
    ST_TRUNCATED = 2'd2
  } status_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [63:0] total_ticks;
    logic [63:0] loop_ticks;
    status_t     status;
  } result_t;

endpackage

### design/command_stream_tick_counter.sv
// Command stream tick counter. Takes one stream byte per cycle and, at the
// end command or at the byte marked last, gives one result with the total
// tick count, the count captured at the loop position and a status (ok, no
// ticks, truncated). A byte is held in an input register and then
// decoded into the stream state by 64-bit adds; its result is loaded
// into the output register as the byte leaves the input register. The
// sustained rate is one byte per cycle: the input stalls only when a byte
// that ends a stream meets a result still waiting on a stalled output.
// Configuration writes are always ready and should be made with the block
// idle; writing data_start also resets the position.
module command_stream_tick_counter
  import cstc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_total_ticks,
  output logic [63:0] out_loop_ticks,
  output logic [1:0]  out_status,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [31:0] cfg_wdata
);

  in_item_t in_item;
  in_item_t item;
  logic     item_valid;
  logic     item_take;
  logic     res_free;
  logic     res_load;
  result_t  res;
  result_t  out_res;

  assign in_item.data_byte = in_data_byte;
  assign in_item.last_byte = in_last_byte;
  assign cfg_ready         = 1'b1;

  // input register
  cstc_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .item_valid (item_valid),
    .item       (item),
    .item_take  (item_take)
  );

  // stream decode and tick accumulation
  cstc_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .item       (item),
    .item_take  (item_take),
    .res_free   (res_free),
    .res_load   (res_load),
    .res        (res),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_sel    (cfg_index),
    .cfg_data   (cfg_wdata)
  );

  // result register
  cstc_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_load  (res_load),
    .res       (res),
    .res_free  (res_free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign out_total_ticks = out_res.total_ticks;
  assign out_loop_ticks  = out_res.loop_ticks;
  assign out_status      = out_res.status;

endmodule

### design/cstc_in_reg.sv
module cstc_in_reg
  import cstc_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_item_t in_item,
  output logic     item_valid,
  output in_item_t item,
  input  logic     item_take
);

  logic     valid_r, valid_nxt;
  in_item_t item_r;
  logic     accept;

  // hold off the sender only while the held request cannot move on
  assign in_stall = valid_r && !item_take;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (accept) begin
      valid_nxt = 1'b1;
    end else if (item_take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // payload capture
  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_item;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

### design/cstc_core.sv
module cstc_core
  import cstc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        item_valid,
  input  in_item_t    item,
  output logic        item_take,
  input  logic        res_free,
  output logic        res_load,
  output result_t     res,
  input  logic        cfg_we,
  input  logic        cfg_sel,
  input  logic [31:0] cfg_data
);

  phase_t                   phase_r, phase_nxt;
  logic [63:0]              total_r, total_nxt;
  logic [63:0]              loop_r, loop_nxt;
  logic [31:0]              pos_r, pos_nxt;
  logic [VARINT_WIDTH-1:0]  vval_r, vval_nxt;
  logic [SHIFT_WIDTH-1:0]   vshift_r, vshift_nxt;
  logic [31:0]              data_start_r;
  logic [31:0]              loop_offset_r;

  // state after the byte itself, before stream end handling
  phase_t                   ph_a;
  logic [63:0]              tot_a;
  logic [63:0]              loop_a;
  logic [VARINT_WIDTH-1:0]  val_a;
  logic [SHIFT_WIDTH-1:0]   sh_a;
  logic [VARINT_WIDTH-1:0]  val_or;
  logic                     shift_open;
  logic                     end_cmd;
  logic                     step;
  logic                     emit;
  logic                     restart;
  logic                     trunc;
  logic                     go;

  // low seven bits placed at the current shift, upper bits dropped
  assign shift_open = vshift_r < SHIFT_WIDTH'(VARINT_WIDTH);
  assign val_or = shift_open
                ? (vval_r | (VARINT_WIDTH'(item.data_byte[VARINT_BITS-1:0])
                             << vshift_r[4:0]))
                : vval_r;

  // per-byte command decode
  always_comb begin
    ph_a    = phase_r;
    tot_a   = total_r;
    loop_a  = loop_r;
    val_a   = vval_r;
    sh_a    = vshift_r;
    end_cmd = 1'b0;
    step    = 1'b1;
    case (phase_r)
      PH_CMD: begin
        if (pos_r == loop_offset_r) begin
          loop_a = total_r;
        end
        if (item.data_byte == CMD_TICK) begin
          tot_a = total_r + 64'd1;
        end else if (item.data_byte == CMD_WAIT) begin
          val_a = '0;
          sh_a  = '0;
          ph_a  = PH_VARINT;
        end else if (item.data_byte == CMD_END) begin
          end_cmd = 1'b1;
        end else begin
          ph_a = PH_SKIP1;
        end
      end
      PH_SKIP1: begin
        ph_a = PH_SKIP2;
      end
      PH_SKIP2: begin
        ph_a = PH_CMD;
      end
      PH_VARINT: begin
        val_a = val_or;
        if (shift_open) begin
          sh_a = vshift_r + SHIFT_WIDTH'(VARINT_BITS);
        end
        if (item.data_byte < VARINT_MORE) begin
          tot_a = total_r + WAIT_BASE_TICKS + 64'(val_or);
          val_a = '0;
          sh_a  = '0;
          ph_a  = PH_CMD;
        end
      end
      default: begin
        step = 1'b0;
      end
    endcase
  end

  // stream end, result and next state
  always_comb begin
    emit    = 1'b0;
    restart = 1'b0;
    trunc   = 1'b0;
    if (phase_r == PH_DONE) begin
      restart = item.last_byte;
    end else if (end_cmd) begin
      emit    = 1'b1;
      restart = item.last_byte;
    end else if (item.last_byte) begin
      emit    = 1'b1;
      trunc   = ph_a != PH_CMD;
      restart = 1'b1;
    end

    go        = item_valid && (!emit || res_free);
    item_take = go;
    res_load  = go && emit;

    res.total_ticks = tot_a;
    res.loop_ticks  = loop_a;
    if (trunc) begin
      res.status = ST_TRUNCATED;
    end else if (tot_a == 64'd0) begin
      res.status = ST_NO_TICKS;
    end else begin
      res.status = ST_OK;
    end

    phase_nxt  = phase_r;
    total_nxt  = total_r;
    loop_nxt   = loop_r;
    pos_nxt    = pos_r;
    vval_nxt   = vval_r;
    vshift_nxt = vshift_r;
    if (go) begin
      if (restart) begin
        phase_nxt  = PH_CMD;
        total_nxt  = '0;
        loop_nxt   = '0;
        pos_nxt    = data_start_r;
        vval_nxt   = '0;
        vshift_nxt = '0;
      end else begin
        phase_nxt  = end_cmd ? PH_DONE : ph_a;
        total_nxt  = tot_a;
        loop_nxt   = loop_a;
        vval_nxt   = val_a;
        vshift_nxt = sh_a;
        pos_nxt    = (step && !end_cmd) ? pos_r + 32'd1 : pos_r;
      end
    end

    // a data_start write also reloads the position
    if (cfg_we && cfg_sel == CFG_DATA_START) begin
      pos_nxt = cfg_data;
    end
  end

  // stream state and configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_CMD;
      total_r       <= '0;
      loop_r        <= '0;
      pos_r         <= '0;
      vval_r        <= '0;
      vshift_r      <= '0;
      data_start_r  <= '0;
      loop_offset_r <= '0;
    end else begin
      phase_r  <= phase_nxt;
      total_r  <= total_nxt;
      loop_r   <= loop_nxt;
      pos_r    <= pos_nxt;
      vval_r   <= vval_nxt;
      vshift_r <= vshift_nxt;
      if (cfg_we) begin
        if (cfg_sel == CFG_DATA_START) begin
          data_start_r <= cfg_data;
        end else begin
          loop_offset_r <= cfg_data;
        end
      end
    end
  end

endmodule

### design/cstc_out_reg.sv
module cstc_out_reg
  import cstc_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    res_load,
  input  result_t res,
  output logic    res_free,
  output logic    out_valid,
  input  logic    out_stall,
  output result_t out_res
);

  logic    valid_r, valid_nxt;
  result_t res_r;

  // free when empty or being taken this cycle
  assign res_free = !valid_r || !out_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (res_load) begin
      valid_nxt = 1'b1;
    end else if (valid_r && !out_stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res_r <= res;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule

### design/cstc_checker.sv
module cstc_checker
  import cstc_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [63:0] out_total_ticks,
  input logic [63:0] out_loop_ticks,
  input logic [1:0]  out_status
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_total_ticks)
      && $stable(out_loop_ticks) && $stable(out_status))
    else $error("result changed while stalled");

  // input back pressure only comes from a stalled pending result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a blocked result");

  // no-ticks status agrees with the total
  a_no_ticks: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_NO_TICKS |-> out_total_ticks == 64'd0)
    else $error("no-ticks status with nonzero total");

  // ok status needs a nonzero total
  a_ok_ticks: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_OK |-> out_total_ticks != 64'd0)
    else $error("ok status with zero total");

  // reset leaves no result pending
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result pending after reset");

endmodule

bind command_stream_tick_counter cstc_checker u_cstc_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_total_ticks (out_total_ticks),
  .out_loop_ticks  (out_loop_ticks),
  .out_status      (out_status)
);

### sim/tb_top.sv
module tb_top;
  import cstc_pkg::*;

  localparam int DRAIN_CYCLES    = 8;
  localparam int RANDOM_PHASES   = 5;
  localparam int BYTES_PER_PHASE = 100;
  localparam int DIRECTED_ROWS   = 25;

  typedef struct {
    logic [7:0]  data;
    logic        last;
    bit          pinned;
    logic [63:0] total;
    logic [63:0] loop;
    status_t     status;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_data_byte = '0;
  logic        in_last_byte = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [63:0] out_total_ticks;
  logic [63:0] out_loop_ticks;
  logic [1:0]  out_status;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = 1'b0;
  logic [31:0] cfg_wdata = '0;

  // stream scanner mirror
  phase_t      scan_phase;
  logic [63:0] tick_sum;
  logic [63:0] loop_sum;
  logic [31:0] byte_pos;
  logic [31:0] vint_val;
  logic [5:0]  vint_shift;
  logic [31:0] start_pos;
  logic [31:0] loop_pos;

  result_t expected_results[$];
  int      mismatches = 0;
  int      items_sent = 0;
  bit      steady = 1'b0;
  bit      pin_on = 1'b0;
  result_t pin_res;

  // extremes, every command kind, end with tail, long varint, truncation
  stim_row_t directed_plan [DIRECTED_ROWS] = '{
    '{CMD_END,  1'b1, 1'b1, 64'd0, 64'd0, ST_NO_TICKS},
    '{CMD_TICK, 1'b0, 1'b0, '0, '0, ST_OK},
    '{CMD_TICK, 1'b0, 1'b0, '0, '0, ST_OK},
    '{CMD_END,  1'b0, 1'b1, 64'd2, 64'd0, ST_OK},
    '{8'h00,    1'b0, 1'b0, '0, '0, ST_OK},
    '{CMD_TICK, 1'b1, 1'b0, '0, '0, ST_OK},
    '{CMD_WAIT, 1'b0, 1'b0, '0, '0, ST_OK},
    '{8'h7f,    1'b1, 1'b1, 64'd129, 64'd0, ST_OK},
    '{CMD_WAIT, 1'b0, 1'b0, '0, '0, ST_OK},
    '{8'hff,    1'b0, 1'b0, '0, '0, ST_OK},
    '{8'hff,    1'b0, 1'b0, '0, '0, ST_OK},
    '{8'hff,    1'b0, 1'b0, '0, '0, ST_OK},
    '{8'hff,    1'b0, 1'b0, '0, '0, ST_OK},
    '{8'hff,    1'b0, 1'b0, '0, '0, ST_OK},
    '{8'h7f,    1'b1, 1'b1, 64'h1_0000_0001, 64'd0, ST_OK},
    '{8'h01,    1'b0, 1'b0, '0, '0, ST_OK},
    '{8'haa,    1'b1, 1'b1, 64'd0, 64'd0, ST_TRUNCATED},
    '{CMD_TICK, 1'b0, 1'b0, '0, '0, ST_OK},
    '{CMD_WAIT, 1'b0, 1'b0, '0, '0, ST_OK},
    '{8'h85,    1'b1, 1'b1, 64'd1, 64'd0, ST_TRUNCATED},
    '{CMD_TICK, 1'b0, 1'b0, '0, '0, ST_OK},
    '{8'h00,    1'b0, 1'b0, '0, '0, ST_OK},
    '{8'hff,    1'b0, 1'b0, '0, '0, ST_OK},
    '{8'hfe,    1'b0, 1'b0, '0, '0, ST_OK},
    '{CMD_TICK, 1'b1, 1'b0, '0, '0, ST_OK}
  };

  command_stream_tick_counter u_top (.*);

  always #10 clk = ~clk;

  // stream state back to its start
  function automatic void restart_scan();
    scan_phase = PH_CMD;
    tick_sum   = '0;
    loop_sum   = '0;
    byte_pos   = start_pos;
    vint_val   = '0;
    vint_shift = '0;
  endfunction

  function automatic result_t stream_summary(input bit truncated);
    result_t r;
    r.total_ticks = tick_sum;
    r.loop_ticks  = loop_sum;
    if (truncated) begin
      r.status = ST_TRUNCATED;
    end else if (tick_sum == 64'd0) begin
      r.status = ST_NO_TICKS;
    end else begin
      r.status = ST_OK;
    end
    return r;
  endfunction

  // advance the scan by one stream byte, giving a result at stream end
  function automatic void scan_byte(input logic [7:0] b, input logic last,
                                    output bit has_result, output result_t r);
    logic [31:0] chunk;
    has_result = 1'b0;
    r          = '0;
    chunk      = {25'd0, b[6:0]};
    // ignored tail after an end command
    if (scan_phase == PH_DONE) begin
      if (last) restart_scan();
      return;
    end
    case (scan_phase)
      PH_CMD: begin
        if (byte_pos == loop_pos) loop_sum = tick_sum;
        if (b == CMD_TICK) begin
          tick_sum = tick_sum + 64'd1;
        end else if (b == CMD_WAIT) begin
          vint_val   = '0;
          vint_shift = '0;
          scan_phase = PH_VARINT;
        end else if (b == CMD_END) begin
          has_result = 1'b1;
          r          = stream_summary(1'b0);
          if (last) begin
            restart_scan();
          end else begin
            scan_phase = PH_DONE;
          end
          return;
        end else begin
          scan_phase = PH_SKIP1;
        end
      end
      PH_SKIP1: scan_phase = PH_SKIP2;
      PH_SKIP2: scan_phase = PH_CMD;
      default: begin
        // varint bytes, high bits past the word dropped
        if (vint_shift < VARINT_WIDTH) begin
          vint_val   = vint_val | (chunk << vint_shift);
          vint_shift = vint_shift + 6'(VARINT_BITS);
        end
        if (b < VARINT_MORE) begin
          tick_sum   = tick_sum + WAIT_BASE_TICKS + {32'd0, vint_val};
          vint_val   = '0;
          vint_shift = '0;
          scan_phase = PH_CMD;
        end
      end
    endcase
    byte_pos = byte_pos + 32'd1;
    if (last) begin
      has_result = 1'b1;
      r          = stream_summary(scan_phase != PH_CMD);
      restart_scan();
    end
  endfunction

  task report_mismatch(input string what, input logic [63:0] got, input logic [63:0] want);
    mismatches++;
    $display("[%0t] %s: got %0h, want %0h", $time, what, got, want);
  endtask

  // one request on the byte channel, waiting out the stall
  task send_request(input logic [7:0] b, input logic last);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_data_byte <= b;
    in_last_byte <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
    @(negedge clk);
  endtask

  task write_reg(input logic idx, input logic [31:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == CFG_DATA_START) begin
      start_pos = value;
      byte_pos  = value;
    end else begin
      loop_pos = value;
    end
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // all results in, then let any ignored tail bytes settle
  task wait_idle();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // one random stream, mostly well formed, closed by a marked last byte
  task automatic play_stream();
    logic [7:0] bytes_q[$];
    int kind;
    int len;
    kind = $urandom_range(0, 9);
    if (kind == 9) begin
      repeat ($urandom_range(1, 8)) bytes_q.push_back(8'($urandom_range(0, 255)));
    end else begin
      repeat ($urandom_range(0, 10)) begin
        case ($urandom_range(0, 3))
          0: bytes_q.push_back(CMD_TICK);
          1: begin
            bytes_q.push_back(CMD_WAIT);
            len = $urandom_range(1, 6);
            repeat (len - 1) bytes_q.push_back(8'($urandom_range(128, 255)));
            bytes_q.push_back(8'($urandom_range(0, 127)));
          end
          default: begin
            bytes_q.push_back(8'($urandom_range(0, 252)));
            repeat (2) bytes_q.push_back(8'($urandom_range(0, 255)));
          end
        endcase
      end
      if (kind <= 2) begin
        bytes_q.push_back(CMD_END);
      end else if (kind <= 4) begin
        // end command followed by an ignored tail
        bytes_q.push_back(CMD_END);
        repeat ($urandom_range(1, 3)) bytes_q.push_back(8'($urandom_range(0, 255)));
      end else if (kind <= 6) begin
        if (bytes_q.size() == 0) bytes_q.push_back(CMD_TICK);
      end else if ($urandom_range(0, 1) == 1) begin
        // operands still owed
        bytes_q.push_back(8'($urandom_range(0, 252)));
        repeat ($urandom_range(0, 1)) bytes_q.push_back(8'($urandom_range(0, 255)));
      end else begin
        // varint still open
        bytes_q.push_back(CMD_WAIT);
        repeat ($urandom_range(0, 3)) bytes_q.push_back(8'($urandom_range(128, 255)));
      end
    end
    foreach (bytes_q[i]) send_request(bytes_q[i], i == bytes_q.size() - 1);
  endtask

  // predict on accepted requests, check accepted results
  always @(posedge clk) begin
    bit      has_result;
    result_t predicted;
    result_t oldest;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        scan_byte(in_data_byte, in_last_byte, has_result, predicted);
        if (pin_on) begin
          expected_results.push_back(pin_res);
        end else if (has_result) begin
          expected_results.push_back(predicted);
        end
      end
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result with nothing expected", out_total_ticks, '0);
        end else begin
          oldest = expected_results.pop_front();
          if (out_total_ticks !== oldest.total_ticks)
            report_mismatch("total_ticks", out_total_ticks, oldest.total_ticks);
          if (out_loop_ticks !== oldest.loop_ticks)
            report_mismatch("loop_ticks", out_loop_ticks, oldest.loop_ticks);
          if (out_status !== oldest.status)
            report_mismatch("status", 64'(out_status), 64'(oldest.status));
        end
      end
    end
  end

  // result side: outside steady phases, stall each new result and release it after a random delay
  initial begin
    int hold;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        @(negedge clk);
        out_stall <= !steady;
      end else if (rst_n && out_valid) begin
        hold = $urandom_range(0, 9);
        @(negedge clk);
        repeat (hold) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    logic [31:0] start_plan [RANDOM_PHASES];
    logic [31:0] loop_plan [RANDOM_PHASES];
    int phase_end;
    start_pos = '0;
    loop_pos  = '0;
    restart_scan();

    // register settings per phase, wrap and never-reached cases included
    start_plan[0] = 32'd0;
    loop_plan[0]  = 32'hffff_ffff;
    start_plan[1] = 32'hffff_fffe;
    loop_plan[1]  = 32'h0000_0001;
    start_plan[2] = 32'hffff_ffff;
    loop_plan[2]  = 32'hffff_ffff;
    start_plan[3] = 32'($urandom);
    loop_plan[3]  = start_plan[3] + 32'($urandom_range(0, 24));
    start_plan[4] = 32'($urandom);
    loop_plan[4]  = start_plan[4] + 32'($urandom_range(0, 24));

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed table on reset register values
    foreach (directed_plan[i]) begin
      pin_on              = directed_plan[i].pinned;
      pin_res.total_ticks = directed_plan[i].total;
      pin_res.loop_ticks  = directed_plan[i].loop;
      pin_res.status      = directed_plan[i].status;
      send_request(directed_plan[i].data, directed_plan[i].last);
    end
    pin_on = 1'b0;
    wait_idle();

    // random streams under each register setting
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      write_reg(CFG_DATA_START, start_plan[p]);
      write_reg(CFG_LOOP_OFFSET, loop_plan[p]);
      steady    = (p % 2 == 1);
      phase_end = items_sent + BYTES_PER_PHASE;
      while (items_sent < phase_end) play_stream();
      wait_idle();
    end

    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
